// ----- hdl/dg_pkg.sv -----
package dg_pkg;

    localparam int FRAC_BITS = 20;
    localparam int ARG_BITS  = 32;
    localparam int OUT_BITS  = 48;
    localparam int Q_BITS    = 53;

    localparam logic [31:0] ONE_F  = 32'd1 << FRAC_BITS;
    localparam logic [31:0] C_RAW  = 32'd17 << (FRAC_BITS - 1);
    localparam logic [31:0] S_RAW  = ONE_F / 32'd100000;
    localparam logic [31:0] S3_Q   = 32'd357913941;
    localparam logic [31:0] S4_Q   = 32'd35791394;
    localparam logic [31:0] S5_Q   = 32'd17043521;
    localparam logic [31:0] LN2_Q  = 32'd2977044472;
    localparam logic [45:0] D1_RND = 46'((64'd2479122403 + 64'd128) >> 8);

    localparam logic [5:0] EXP_TINY = 6'd44;
    localparam logic [5:0] EXP_MAIN = 6'd52;

    typedef struct packed {
        logic        start;
        logic [5:0]  expo;
        logic [31:0] dvsr;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [Q_BITS-1:0]    quo;
    } t_div_rsp;

endpackage

// ----- hdl/digamma_function_top.sv -----
// channel  | dir | tdata                          | tuser
// s        | in  | [31:0] arg_x                   | -
// m        | out | [47:0] psi_value               | [0] domain_error
// One beat in, one beat out. A zero argument goes straight to the output; a tiny
// argument takes a single divide. Otherwise up to ten divides, a normalize, then 32
// squarings and 6 products on the shared multiplier. The input is ready only when
// the sequencer idles; a finished result waits in the output register while the
// next beat enters.
// Reset is synchronous, active low, and clears all control state.
module digamma_function_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] arg_x
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [47:0] psi_value
    output logic [0:0]  o_m_tuser    // [0] domain_error
);

    localparam logic [4:0] S_IDLE = 5'd0,  S_LOOP = 5'd1,  S_RDIV = 5'd2,
                           S_RFIN = 5'd3,  S_TINY = 5'd4,  S_NORM = 5'd5,
                           S_SQM  = 5'd6,  S_SQA  = 5'd7,  S_LNM  = 5'd8,
                           S_LNA  = 5'd9,  S_EM   = 5'd10, S_EA   = 5'd11,
                           S_R2M  = 5'd12, S_R2A  = 5'd13, S_T5M  = 5'd14,
                           S_T5A  = 5'd15, S_T4M  = 5'd16, S_T4A  = 5'd17,
                           S_T3M  = 5'd18, S_T3A  = 5'd19, S_OUT  = 5'd20,
                           S_FIN  = 5'd21;

    logic [4:0]         r_state;
    logic [31:0]        r_y;
    logic [3:0]         r_n;
    logic signed [63:0] r_acc;
    logic [31:0]        r_r;
    logic [31:0]        r_m;
    logic [5:0]         r_cnt;
    logic [4:0]         r_p;
    logic [31:0]        r_frac;
    logic [31:0]        r_r2;
    logic [31:0]        r_t;
    logic [47:0]        r_res;
    logic               r_err;
    logic               r_ovalid;
    logic [47:0]        r_opsi;
    logic               r_oerr;

    dg_pkg::t_div_req   w_req;
    dg_pkg::t_div_rsp   w_rsp;
    logic [31:0]        w_a;
    logic [31:0]        w_b;
    logic [63:0]        w_prod;
    logic [31:0]        w_rnd;
    logic [31:0]        w_x;
    logic               w_acc;
    logic [45:0]        w_tm;
    logic [47:0]        w_mo;
    logic signed [63:0] w_sh;

    assign w_x        = i_s_tdata;
    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        w_req.start = 1'b0;
        w_req.expo  = dg_pkg::EXP_MAIN;
        w_req.dvsr  = r_y;
        if (r_state == S_IDLE) begin
            w_req.start = w_acc && (w_x != 32'd0) && (w_x <= dg_pkg::S_RAW);
            w_req.expo  = dg_pkg::EXP_TINY;
            w_req.dvsr  = w_x;
        end else if (r_state == S_LOOP) begin
            w_req.start = 1'b1;
        end
    end

    dg_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    always_comb begin
        w_a = r_r2;
        w_b = r_t;
        unique case (r_state)
            S_SQM:   begin w_a = r_m;    w_b = r_m;            end
            S_LNM:   begin w_a = r_frac; w_b = dg_pkg::LN2_Q;  end
            S_EM:    begin w_a = 32'(r_p - 5'd20); w_b = dg_pkg::LN2_Q; end
            S_R2M:   begin w_a = r_r;    w_b = r_r;            end
            S_T5M:   begin w_a = dg_pkg::S5_Q; w_b = r_r2;     end
            default: begin w_a = r_r2;   w_b = r_t;            end
        endcase
    end

    dg_mul u_mul (.i_clk(i_clk), .i_a(w_a), .i_b(w_b), .o_p(w_prod));

    assign w_rnd = 32'(({1'b0, w_prod} + 65'd2147483648) >> 32);
    assign w_tm  = w_rsp.quo[45:0] + dg_pkg::D1_RND;
    assign w_mo  = 48'((w_tm + 46'd8) >> 4);
    assign w_sh  = (r_acc + 64'sd2048) >>> 12;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // drop the beat once taken, unless a new one is loaded below
            if (r_ovalid && i_m_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (w_acc) begin
                    r_y   <= w_x;
                    r_acc <= '0;
                    r_n   <= 4'd0;
                    if (w_x == 32'd0) begin
                        r_res   <= '0;
                        r_err   <= 1'b1;
                        r_state <= S_OUT;
                    end else if (w_x <= dg_pkg::S_RAW) begin
                        r_state <= S_TINY;
                    end else begin
                        r_state <= S_LOOP;
                    end
                end
                S_TINY: if (w_rsp.done) begin
                    r_res   <= 48'd0 - w_mo;
                    r_err   <= 1'b0;
                    r_state <= S_OUT;
                end
                S_LOOP: begin
                    r_state <= (r_y < dg_pkg::C_RAW && r_n < 4'd9) ? S_RDIV : S_RFIN;
                end
                S_RDIV: if (w_rsp.done) begin
                    r_acc   <= r_acc - $signed({11'd0, w_rsp.quo});
                    r_y     <= r_y + dg_pkg::ONE_F;
                    r_n     <= r_n + 4'd1;
                    r_state <= S_LOOP;
                end
                S_RFIN: if (w_rsp.done) begin
                    r_r     <= w_rsp.quo[31:0];
                    r_acc   <= r_acc - $signed({31'd0, 33'({1'b0, w_rsp.quo[31:0]} + 33'd1) >> 1});
                    r_m     <= r_y;
                    r_cnt   <= 6'd0;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    // shift the leading one up to bit 31, then back to bit 30
                    if (r_m[31]) begin
                        r_m     <= {1'b0, r_m[31:1]};
                        r_p     <= 5'd31 - r_cnt[4:0];
                        r_cnt   <= 6'd0;
                        r_frac  <= '0;
                        r_state <= S_SQM;
                    end else begin
                        r_m   <= {r_m[30:0], 1'b0};
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_SQM: r_state <= S_SQA;
                S_SQA: begin
                    if (w_prod[61]) begin
                        r_m    <= {1'b0, w_prod[61:31]};
                        r_frac <= {r_frac[30:0], 1'b1};
                    end else begin
                        r_m    <= w_prod[61:30];
                        r_frac <= {r_frac[30:0], 1'b0};
                    end
                    r_cnt   <= r_cnt + 6'd1;
                    r_state <= (r_cnt == 6'd31) ? S_LNM : S_SQM;
                end
                S_LNM: r_state <= S_LNA;
                S_LNA: begin
                    r_acc   <= r_acc + $signed({32'd0, w_prod[63:32]});
                    r_state <= S_EM;
                end
                S_EM: r_state <= S_EA;
                S_EA: begin
                    r_acc   <= r_acc + $signed(w_prod);
                    r_state <= S_R2M;
                end
                S_R2M: r_state <= S_R2A;
                S_R2A: begin
                    r_r2    <= w_rnd;
                    r_state <= S_T5M;
                end
                S_T5M: r_state <= S_T5A;
                S_T5A: begin
                    r_t     <= dg_pkg::S4_Q - w_rnd;
                    r_state <= S_T4M;
                end
                S_T4M: r_state <= S_T4A;
                S_T4A: begin
                    r_t     <= dg_pkg::S3_Q - w_rnd;
                    r_state <= S_T3M;
                end
                S_T3M: r_state <= S_T3A;
                S_T3A: begin
                    r_acc   <= r_acc - $signed({32'd0, w_rnd});
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_res   <= w_sh[47:0];
                    r_err   <= 1'b0;
                    r_state <= S_OUT;
                end
                S_OUT: if (!r_ovalid || i_m_tready) begin
                    r_ovalid <= 1'b1;
                    r_opsi   <= r_res;
                    r_oerr   <= r_err;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid   = r_ovalid;
    assign o_m_tdata    = r_opsi;
    assign o_m_tuser[0] = r_oerr;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == 48'd0))
        else $error("domain error with nonzero value");
    a_loop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDIV) |-> (r_n < 4'd9)) else $error("too many reductions");
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQM || r_state == S_SQA) |-> !o_s_tready)
        else $error("ready during log");

endmodule

// ----- hdl/dg_div.sv -----
module dg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dg_pkg::t_div_req  i_req,
    output dg_pkg::t_div_rsp  o_rsp
);

    logic                       r_busy;
    logic                       r_first;
    logic [5:0]                 r_cnt;
    logic [31:0]                r_d;
    logic [31:0]                r_rem;
    logic [dg_pkg::Q_BITS-1:0]  r_q;
    logic                       r_done;
    logic [32:0]                w_trial;
    logic                       w_ge;

    // one quotient bit per cycle of floor(2^expo / d)
    assign w_trial = {r_rem, r_first};
    assign w_ge    = w_trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_first <= 1'b1;
                r_cnt   <= i_req.expo;
                r_d     <= i_req.dvsr;
                r_rem   <= '0;
                r_q     <= '0;
            end else if (r_busy) begin
                r_first <= 1'b0;
                r_rem   <= w_ge ? 32'(w_trial - {1'b0, r_d}) : w_trial[31:0];
                r_q     <= {r_q[dg_pkg::Q_BITS-2:0], w_ge};
                r_cnt   <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without work");

endmodule

// ----- hdl/dg_mul.sv -----
module dg_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int N_RANDOM   = 430;
    localparam int DRAIN_CYC  = 700;
    localparam int HOLD_CYC   = 3000;

    typedef struct packed {
        logic [47:0] psi;
        logic        err;
    } t_psi_beat;

    typedef struct {
        logic [31:0] x;
        bit          known;
        logic [47:0] psi;
        logic        err;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;
    logic [0:0]  o_m_tuser;

    t_psi_beat psi_expected_q[$];
    int        n_mismatch;
    int        n_results;
    int        n_tiny;
    int        n_zero;
    int        tx_idle_pct;
    int        rx_idle_pct;
    int        rx_hold_left;
    int        rx_hold_req;
    int        rx_hold_seen;

    digamma_function_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("Timeout with %0d results outstanding", psi_expected_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint unsigned round_shift(longint unsigned v, int s);
        if (s == 0) return v;
        return (v + (64'd1 << (s - 1))) >> s;
    endfunction

    // floor(2^(FRAC_BITS+k) / d), restoring style
    function automatic longint unsigned recip_fx(longint unsigned d, int k);
        longint unsigned q;
        longint unsigned r;
        if (d == 0) return 0;
        q = 64'(dg_pkg::ONE_F) / d;
        r = 64'(dg_pkg::ONE_F) % d;
        for (int i = 0; i < k; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // natural log in Q.32 by normalize and repeated squaring
    function automatic longint unsigned ln_fx(longint unsigned y);
        int              p;
        int              e;
        longint unsigned m;
        longint unsigned frac;
        longint unsigned v;
        p = 0;
        v = y;
        while (v > 1) begin
            v = v >> 1;
            p++;
        end
        e = (p > dg_pkg::FRAC_BITS) ? p - dg_pkg::FRAC_BITS : 0;
        m = (p > 30) ? (y >> (p - 30)) : (y << (30 - p));
        frac = 0;
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return 64'(e) * 64'(dg_pkg::LN2_Q) + ((frac * 64'(dg_pkg::LN2_Q)) >> 32);
    endfunction

    function automatic t_psi_beat predict_psi(logic [31:0] arg);
        t_psi_beat       b;
        longint unsigned x;
        longint unsigned y;
        longint unsigned r;
        longint unsigned r2;
        longint unsigned t;
        longint unsigned u;
        longint unsigned m;
        longint          acc;
        longint          res;
        int              n;
        x = 64'(arg);
        b.err = 1'b0;
        if (x == 0) begin
            b.psi = '0;
            b.err = 1'b1;
        end else if (x <= 64'(dg_pkg::S_RAW)) begin
            m = recip_fx(x, dg_pkg::FRAC_BITS + 4)
              + round_shift(64'd2479122403, 28 - dg_pkg::FRAC_BITS);
            m = round_shift(m, 4);
            if (m > (64'd1 << 47)) m = 64'd1 << 47;
            b.psi = 48'(64'd0 - m);
        end else begin
            acc = 0;
            y = x;
            n = 0;
            while (y < 64'(dg_pkg::C_RAW) && n < 9) begin
                acc = acc - longint'(recip_fx(y, 32));
                y = y + 64'(dg_pkg::ONE_F);
                n++;
            end
            r = recip_fx(y, 32);
            acc = acc + longint'(ln_fx(y));
            acc = acc - longint'((r + 1) >> 1);
            r2 = round_shift(r * r, 32);
            t = 64'(dg_pkg::S4_Q) - round_shift(64'(dg_pkg::S5_Q) * r2, 32);
            t = 64'(dg_pkg::S3_Q) - round_shift(r2 * t, 32);
            t = round_shift(r2 * t, 32);
            acc = acc - longint'(t);
            u = (64'(acc) + (64'd1 << 62) + (64'd1 << 11)) >> 12;
            res = longint'(u) - longint'((64'd1 << 62) >> 12);
            if (res > 64'sh7FFF_FFFF_FFFF) res = 64'sh7FFF_FFFF_FFFF;
            if (res < -64'sh8000_0000_0000) res = -64'sh8000_0000_0000;
            b.psi = res[47:0];
        end
        return b;
    endfunction

    // offer one argument beat, hold until accepted
    task automatic send_arg(logic [31:0] x, bit known, t_psi_beat typed);
        t_psi_beat exp_beat;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= x;
        do @(posedge i_clk); while (!o_s_tready);
        exp_beat = known ? typed : predict_psi(x);
        psi_expected_q = {psi_expected_q, exp_beat};
        if (x == 0) n_zero++;
        else if (x <= dg_pkg::S_RAW) n_tiny++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_arg();
        int sel;
        sel = $urandom_range(99);
        if (sel < 4) return '0;
        if (sel < 20) return $urandom_range(1, dg_pkg::S_RAW + 2);
        if (sel < 60) return $urandom_range(dg_pkg::S_RAW + 1, 10 * dg_pkg::ONE_F);
        if (sel < 75) return $urandom_range(dg_pkg::ONE_F, 20'hFFFFF * 4);
        return $urandom;
    endfunction

    // receiver: random stalls plus a long hold on request
    always @(negedge i_clk) begin
        if (rx_hold_seen != rx_hold_req) begin
            rx_hold_seen <= rx_hold_req;
            rx_hold_left <= HOLD_CYC;
            i_m_tready   <= 1'b0;
        end else if (rx_hold_left > 0) begin
            i_m_tready   <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_psi_beat want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_results++;
            if (psi_expected_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("Unexpected result beat psi=%h err=%b", o_m_tdata, o_m_tuser);
            end else begin
                want = psi_expected_q.pop_front();
                if (o_m_tdata !== want.psi || o_m_tuser[0] !== want.err) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("Mismatch on beat %0d: psi exp %h got %h, err exp %b got %b",
                                 n_results, want.psi, o_m_tdata, want.err, o_m_tuser[0]);
                end
            end
        end
    end

    t_stim_row dir_tbl[] = '{
        '{32'h0000_0000,           1'b1, 48'h0, 1'b1},
        '{32'h0000_0001,           1'b0, 48'h0, 1'b0},
        '{32'h0000_0002,           1'b0, 48'h0, 1'b0},
        '{32'h0000_0007,           1'b0, 48'h0, 1'b0},
        '{dg_pkg::S_RAW,           1'b0, 48'h0, 1'b0},
        '{dg_pkg::S_RAW + 1,       1'b0, 48'h0, 1'b0},
        '{32'h0000_0000,           1'b1, 48'h0, 1'b1},
        '{dg_pkg::ONE_F / 2,       1'b0, 48'h0, 1'b0},
        '{dg_pkg::ONE_F,           1'b0, 48'h0, 1'b0},
        '{dg_pkg::ONE_F + 1,       1'b0, 48'h0, 1'b0},
        '{2 * dg_pkg::ONE_F,       1'b0, 48'h0, 1'b0},
        '{dg_pkg::C_RAW - 1,       1'b0, 48'h0, 1'b0},
        '{dg_pkg::C_RAW,           1'b0, 48'h0, 1'b0},
        '{dg_pkg::C_RAW + 1,       1'b0, 48'h0, 1'b0},
        '{9 * dg_pkg::ONE_F,       1'b0, 48'h0, 1'b0},
        '{32'h0010_0001,           1'b0, 48'h0, 1'b0},
        '{32'h5555_5555,           1'b0, 48'h0, 1'b0},
        '{32'hAAAA_AAAA,           1'b0, 48'h0, 1'b0},
        '{32'h8000_0000,           1'b0, 48'h0, 1'b0},
        '{32'h7FFF_FFFF,           1'b0, 48'h0, 1'b0},
        '{32'hFFFF_FFFF,           1'b0, 48'h0, 1'b0}
    };

    initial begin
        t_psi_beat typed;
        int        wait_cyc;
        n_tiny       = 0;
        n_zero       = 0;
        tx_idle_pct  = 19;
        rx_idle_pct  = 58;
        rx_hold_req  = 0;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tbl[i]) begin
            typed.psi = dir_tbl[i].psi;
            typed.err = dir_tbl[i].err;
            send_arg(dir_tbl[i].x, dir_tbl[i].known, typed);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM / 3) begin
                tx_idle_pct = 58;
                rx_idle_pct = 19;
            end
            if (k == 2 * N_RANDOM / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // long receiver hold while the sender keeps offering
            if (k == 40) rx_hold_req++;
            // pause until the pipe is empty
            if (k == 200) begin
                i_s_tvalid <= 1'b0;
                wait (psi_expected_q.size() == 0);
                @(negedge i_clk);
            end
            send_arg(rand_arg(), 1'b0, typed);
        end
        i_s_tvalid <= 1'b0;

        wait_cyc = 0;
        while (psi_expected_q.size() != 0 && wait_cyc < 200_000) begin
            @(posedge i_clk);
            wait_cyc++;
        end
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("Covered %0d arguments (%0d zero, %0d tiny), %0d results checked",
                 dir_tbl.size() + N_RANDOM, n_zero, n_tiny, n_results);
        $display("Stall phases: sender-heavy, receiver-heavy, none; one long output hold");
        if (n_mismatch == 0 && psi_expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", n_mismatch,
                     psi_expected_q.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
